// ===== rtl/core/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// implication checked every clock outside reset
`define ASSERT_IMPL(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("assertion failed");
// next-cycle implication checked every clock outside reset
`define ASSERT_NEXT(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("assertion failed");
`endif

// ===== rtl/core/bloom_pkg.sv =====
package bloom_pkg;
   localparam int FILTER_BITS_DEF = 65536;
   localparam int MAX_HASHES_DEF  = 32;
   localparam logic [31:0] SEED_A = 32'hDEADBEEF;
   localparam logic [31:0] SEED_B = 32'hCAFECAFE;
   localparam logic [31:0] MIX_C1 = 32'hcc9e2d51;
   localparam logic [31:0] MIX_C2 = 32'h1b873593;
   localparam logic [31:0] FMIX_1 = 32'h85ebca6b;
   localparam logic [31:0] FMIX_2 = 32'hc2b2ae35;
   localparam logic [31:0] ADD_N  = 32'he6546b64;
   localparam logic [0:0] CSR_NUM_HASHES  = 1'd0;
   localparam logic [0:0] CSR_BITS_IN_USE = 1'd1;
   localparam logic ACT_INSERT = 1'b0;
   localparam logic ACT_QUERY  = 1'b1;

   typedef enum logic [3:0] {
      ST_CLEAR, ST_IDLE, ST_MUL1, ST_MUL2, ST_ABS, ST_TAIL, ST_FIN1, ST_FIN2,
      ST_PROBE_SET, ST_MOD, ST_ACCESS, ST_READ, ST_DONE
   } state_type;

   typedef enum logic [2:0] {
      MS_K1, MS_K2, MS_H5, MS_F1, MS_F2, MS_IH2
   } mul_sel_type;

   function automatic logic [31:0] rotl(input logic [31:0] x, input int r);
      rotl = (x << r) | (x >> (32 - r));
   endfunction
endpackage

// ===== rtl/core/bloom_ram.sv =====
module bloom_ram #(
   parameter int WIDTH = 1,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule

// ===== rtl/core/bloom_mod.sv =====
module bloom_mod (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [31:0] dividend,
   input  logic [20:0] divisor,
   output logic        done,
   output logic [20:0] remainder
);
   logic [21:0] rem_ff, rem_in;
   logic [31:0] quo_ff, quo_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in;
   logic [21:0] trial;

   always_comb begin
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      trial   = {rem_ff[20:0], quo_ff[31]} - {1'b0, divisor};
      if (start) begin
         rem_in  = '0;
         quo_in  = dividend;
         cnt_in  = 6'd32;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (!trial[21]) begin
            rem_in = trial;
         end else begin
            rem_in = {rem_ff[20:0], quo_ff[31]};
         end
         quo_in = {quo_ff[30:0], 1'b0};
         cnt_in = cnt_ff - 6'd1;
         if (cnt_ff == 6'd1) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
   end

   assign done      = busy_ff && (cnt_ff == 6'd1);
   assign remainder = rem_in[20:0];
endmodule

// ===== rtl/core/bloom_filter_insert_query_top.sv =====
// Bloom filter, insert and query of byte-string keys.
// req_ channel: one word per handshake (key_word little endian, bytes_valid,
// last_word, action). rsp_ channel: one word per key (kind, present).
// csr_ port: index 0 num_hashes, index 1 bits_in_use; write only while idle.
// Each word is accepted in ST_IDLE, scrambled in the shared 32x32 multiplier
// (ST_MUL1, ST_MUL2) and absorbed into both hashes in turn (ST_ABS); a short
// last word skips the absorb. The last word then finalizes both hashes
// (ST_TAIL, ST_FIN1, ST_FIN2 per hash); per probe the block multiplies in
// ST_PROBE_SET, runs the bit-serial modulo and writes (insert) or reads
// (query) the bit store; ST_DONE closes the key. The serial modulo sets the
// rate. Reset starts a clearing pass over every bit of the bit store;
// req_stall is high during it. While a result waits under rsp_stall the
// block holds it in the output register, goes on taking the next key, and
// holds that key's result until the output register is free.
module bloom_filter_insert_query_top #(
   parameter int FILTER_BITS = bloom_pkg::FILTER_BITS_DEF,
   parameter int MAX_HASHES  = bloom_pkg::MAX_HASHES_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_action,
   input  logic [31:0] req_key_word,
   input  logic [2:0]  req_bytes_valid,
   input  logic        req_last_word,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_kind,
   output logic        rsp_present,
   input  logic        csr_write,
   input  logic [0:0]  csr_index,
   input  logic [16:0] csr_data
);
`include "assert_macros.svh"
   localparam int AW = $clog2(FILTER_BITS);

   bloom_pkg::state_type state_ff, state_in;
   bloom_pkg::mul_sel_type msel;
   logic [5:0]  nh_ff;
   logic [16:0] biu_ff;
   logic [31:0] ha_ff, ha_in, hb_ff, hb_in, len_ff, len_in;
   logic [31:0] word_ff, word_in;
   logic [2:0]  nb_ff, nb_in;
   logic        last_ff, last_in, act_ff, act_in, side_ff, side_in;
   logic [31:0] acc_ff, acc_in;
   logic [6:0]  pi_ff, pi_in;
   logic [AW-1:0] clr_ff, clr_in;
   logic        allset_ff, allset_in;
   logic        rv_ff, rv_in, rk_ff, rk_in, rp_ff, rp_in;
   logic [31:0] mul_a, mul_b, prod_ff;
   logic [31:0] mul_p;
   logic        mod_start, mod_done;
   logic [20:0] mod_rem, m_eff;
   logic [AW-1:0] idx_ff, idx_in;
   logic        ram_we, ram_wd, ram_rd;
   logic [AW-1:0] ram_wa;
   logic [6:0]  k_eff;
   logic [31:0] tmask, hsel, fin;

   always_comb begin
      if ({1'b0, nh_ff} > 7'(MAX_HASHES)) begin
         k_eff = 7'(MAX_HASHES);
      end else begin
         k_eff = {1'b0, nh_ff};
      end
      if (biu_ff == 17'd0) begin
         m_eff = 21'd1;
      end else if ({4'd0, biu_ff} > 21'(FILTER_BITS)) begin
         m_eff = 21'(FILTER_BITS);
      end else begin
         m_eff = {4'd0, biu_ff};
      end
      case (nb_ff)
         3'd1:    tmask = 32'h0000_00ff;
         3'd2:    tmask = 32'h0000_ffff;
         3'd3:    tmask = 32'h00ff_ffff;
         default: tmask = 32'hffff_ffff;
      endcase
   end

   always_comb begin
      hsel = side_ff ? hb_ff : ha_ff;
      case (msel)
         bloom_pkg::MS_K1: begin mul_a = word_ff & tmask; mul_b = bloom_pkg::MIX_C1; end
         bloom_pkg::MS_K2: begin
            mul_a = bloom_pkg::rotl(prod_ff, 15); mul_b = bloom_pkg::MIX_C2;
         end
         bloom_pkg::MS_H5: begin mul_a = hsel; mul_b = 32'd5; end
         bloom_pkg::MS_F1: begin mul_a = hsel; mul_b = bloom_pkg::FMIX_1; end
         bloom_pkg::MS_F2: begin mul_a = hsel; mul_b = bloom_pkg::FMIX_2; end
         default: begin mul_a = 32'(pi_ff); mul_b = hb_ff; end
      endcase
      mul_p = mul_a * mul_b;
   end

   bloom_mod u_mod (
      .clock(clock), .reset(reset), .start(mod_start), .dividend(acc_ff),
      .divisor(m_eff), .done(mod_done), .remainder(mod_rem)
   );

   bloom_ram #(.WIDTH(1), .DEPTH(FILTER_BITS)) u_ram (
      .clock(clock), .wr_en(ram_we), .wr_addr(ram_wa), .wr_data(ram_wd),
      .rd_addr(idx_ff), .rd_data(ram_rd)
   );

   always_comb begin
      state_in = state_ff;
      ha_in = ha_ff; hb_in = hb_ff; len_in = len_ff;
      word_in = word_ff; nb_in = nb_ff; last_in = last_ff; act_in = act_ff;
      side_in = side_ff; acc_in = acc_ff; pi_in = pi_ff; clr_in = clr_ff;
      allset_in = allset_ff; idx_in = idx_ff;
      rv_in = rv_ff; rk_in = rk_ff; rp_in = rp_ff;
      msel = bloom_pkg::MS_K1;
      mod_start = 1'b0;
      ram_we = 1'b0; ram_wa = idx_ff; ram_wd = 1'b1;
      fin = hsel;
      req_stall = 1'b1;
      if (rv_ff && !rsp_stall) begin
         rv_in = 1'b0;
      end
      case (state_ff)
         bloom_pkg::ST_CLEAR: begin
            ram_we = 1'b1; ram_wa = clr_ff; ram_wd = 1'b0;
            clr_in = clr_ff + AW'(1);
            if (clr_ff == AW'(FILTER_BITS - 1)) begin
               state_in = bloom_pkg::ST_IDLE;
            end
         end
         bloom_pkg::ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               word_in = req_key_word;
               act_in  = req_action;
               last_in = req_last_word;
               nb_in   = (!req_last_word || req_bytes_valid > 3'd4) ? 3'd4 : req_bytes_valid;
               side_in = 1'b0;
               state_in = bloom_pkg::ST_MUL1;
            end
         end
         bloom_pkg::ST_MUL1: begin
            if (nb_ff == 3'd4) begin
               msel = bloom_pkg::MS_K1;
            end else begin
               msel = bloom_pkg::MS_K1;
            end
            state_in = bloom_pkg::ST_MUL2;
         end
         bloom_pkg::ST_MUL2: begin
            msel = bloom_pkg::MS_K2;
            len_in = len_ff + 32'(nb_ff);
            if (nb_ff == 3'd4) begin
               ha_in = bloom_pkg::rotl(ha_ff ^ mul_p, 13);
               hb_in = bloom_pkg::rotl(hb_ff ^ mul_p, 13);
               side_in = 1'b0;
               state_in = bloom_pkg::ST_ABS;
            end else begin
               if (nb_ff != 3'd0) begin
                  ha_in = ha_ff ^ mul_p;
                  hb_in = hb_ff ^ mul_p;
               end
               state_in = bloom_pkg::ST_TAIL;
            end
         end
         bloom_pkg::ST_ABS: begin
            msel = bloom_pkg::MS_H5;
            if (!side_ff) begin
               ha_in = mul_p + bloom_pkg::ADD_N;
               side_in = 1'b1;
            end else begin
               hb_in = mul_p + bloom_pkg::ADD_N;
               side_in = 1'b0;
               if (last_ff) begin
                  state_in = bloom_pkg::ST_TAIL;
               end else begin
                  state_in = bloom_pkg::ST_IDLE;
               end
            end
         end
         bloom_pkg::ST_TAIL: begin
            fin = hsel ^ len_ff;
            fin = fin ^ (fin >> 16);
            if (!side_ff) begin
               ha_in = fin;
            end else begin
               hb_in = fin;
            end
            state_in = bloom_pkg::ST_FIN1;
         end
         bloom_pkg::ST_FIN1: begin
            msel = bloom_pkg::MS_F1;
            fin = mul_p ^ (mul_p >> 13);
            if (!side_ff) begin
               ha_in = fin;
            end else begin
               hb_in = fin;
            end
            state_in = bloom_pkg::ST_FIN2;
         end
         bloom_pkg::ST_FIN2: begin
            msel = bloom_pkg::MS_F2;
            fin = mul_p ^ (mul_p >> 16);
            if (!side_ff) begin
               ha_in = fin;
               side_in = 1'b1;
               state_in = bloom_pkg::ST_TAIL;
            end else begin
               hb_in = fin;
               side_in = 1'b0;
               pi_in = '0;
               allset_in = 1'b1;
               state_in = bloom_pkg::ST_PROBE_SET;
            end
         end
         bloom_pkg::ST_PROBE_SET: begin
            msel = bloom_pkg::MS_IH2;
            acc_in = ha_ff + mul_p;
            if (pi_ff >= k_eff || !allset_ff) begin
               state_in = bloom_pkg::ST_DONE;
            end else begin
               state_in = bloom_pkg::ST_MOD;
            end
         end
         bloom_pkg::ST_MOD: begin
            mod_start = (acc_ff == acc_ff) && !side_ff;
            side_in = 1'b1;
            if (mod_done) begin
               idx_in = AW'(mod_rem);
               side_in = 1'b0;
               state_in = bloom_pkg::ST_ACCESS;
            end
         end
         bloom_pkg::ST_ACCESS: begin
            if (act_ff == bloom_pkg::ACT_INSERT) begin
               ram_we = 1'b1;
               pi_in = pi_ff + 7'd1;
               state_in = bloom_pkg::ST_PROBE_SET;
            end else begin
               state_in = bloom_pkg::ST_READ;
            end
         end
         bloom_pkg::ST_READ: begin
            allset_in = ram_rd;
            pi_in = pi_ff + 7'd1;
            state_in = bloom_pkg::ST_PROBE_SET;
         end
         bloom_pkg::ST_DONE: begin
            if (!rv_ff || !rsp_stall) begin
               rv_in = 1'b1;
               rk_in = act_ff;
               rp_in = (act_ff == bloom_pkg::ACT_QUERY) && allset_ff;
               ha_in = bloom_pkg::SEED_A;
               hb_in = bloom_pkg::SEED_B;
               len_in = '0;
               state_in = bloom_pkg::ST_IDLE;
            end
         end
         default: state_in = bloom_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= bloom_pkg::ST_CLEAR;
         clr_ff <= '0;
         rv_ff <= 1'b0;
         nh_ff <= 6'd4;
         biu_ff <= 17'd65536;
         ha_ff <= bloom_pkg::SEED_A;
         hb_ff <= bloom_pkg::SEED_B;
         len_ff <= '0;
         side_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         clr_ff <= clr_in;
         rv_ff <= rv_in;
         ha_ff <= ha_in;
         hb_ff <= hb_in;
         len_ff <= len_in;
         side_ff <= side_in;
         if (csr_write && csr_index == bloom_pkg::CSR_NUM_HASHES) begin
            nh_ff <= csr_data[5:0];
         end
         if (csr_write && csr_index == bloom_pkg::CSR_BITS_IN_USE) begin
            biu_ff <= csr_data;
         end
      end
      prod_ff <= mul_p;
      word_ff <= word_in; nb_ff <= nb_in; last_ff <= last_in; act_ff <= act_in;
      acc_ff <= acc_in; pi_ff <= pi_in; allset_ff <= allset_in; idx_ff <= idx_in;
      rk_ff <= rk_in; rp_ff <= rp_in;
   end

   assign rsp_valid   = rv_ff;
   assign rsp_kind    = rk_ff;
   assign rsp_present = rp_ff;

   `ASSERT_IMPL(a_no_req_while_busy, clock, reset,
      state_ff != bloom_pkg::ST_IDLE, req_stall)
   `ASSERT_NEXT(a_done_gives_rsp, clock, reset,
      state_ff == bloom_pkg::ST_DONE, rsp_valid)
   `ASSERT_IMPL(a_insert_not_present, clock, reset,
      rsp_valid && rsp_kind == bloom_pkg::ACT_INSERT, !rsp_present)
endmodule
